[design/itaf_pkg.sv]
// Shared types and constants for the integer to ASCII formatter.
package itaf_pkg;

    localparam logic [2:0] C_CMD_SDEC32 = 3'd0;
    localparam logic [2:0] C_CMD_UDEC32 = 3'd1;
    localparam logic [2:0] C_CMD_HEX32L = 3'd2;
    localparam logic [2:0] C_CMD_HEX32U = 3'd3;
    localparam logic [2:0] C_CMD_HEX64L = 3'd4;

    localparam logic [6:0] C_ASCII_ZERO  = 7'd48;
    localparam logic [6:0] C_ASCII_MINUS = 7'd45;
    localparam logic [6:0] C_LOWER_OFF   = 7'd87;
    localparam logic [6:0] C_UPPER_OFF   = 7'd55;

    localparam int C_BIN_W  = 32;
    localparam int C_BCD_W  = 40;
    localparam int C_DIG_W  = 64;
    localparam logic [4:0] C_DEC_DIGITS   = 5'd10;
    localparam logic [4:0] C_HEX32_DIGITS = 5'd8;
    localparam logic [4:0] C_HEX64_DIGITS = 5'd16;

    // Digit string handed to the emitter, left aligned, most significant nibble on top.
    typedef struct packed {
        logic                 valid;
        logic [C_DIG_W-1:0]   dig;
        logic [4:0]           n;
        logic                 neg;
        logic                 upper;
    } t_load;

endpackage

[design/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter.
// Input channel: i_in_valid/o_in_ready carry i_command and i_value. Output channel:
// o_out_valid/i_out_ready carry o_character, o_last and o_char_count, one character
// per transfer, most significant first, o_last on the final one.
// One number is in flight at a time; o_in_ready rises again in the cycle after the
// transfer of the last character. Unknown commands are taken and dropped.
// Decimal modes: the serial BCD converter runs, its result loads the digit shifter,
// leading zeros are dropped, then one character per cycle while the receiver is ready
// (sign first if negative).
// Hex modes: leading zeros dropped, then one character per cycle unless stalled.
// A stalled receiver holds the current character in the output register and the
// digit shifter waits; nothing is lost.
// Reset clears all control state; no number is in flight afterwards.
module integer_to_ascii_formatter
    import itaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_character,
    output logic        o_last,
    output logic [4:0]  o_char_count
);

    logic               r_busy;
    logic               r_neg;
    t_load              load;
    logic               accept;
    logic               is_dec;
    logic               is_hex;
    logic               bcd_start;
    logic               bcd_done;
    logic [C_BCD_W-1:0] bcd;
    logic [31:0]        mag;

    assign accept = i_in_valid && o_in_ready;
    assign is_dec = i_command inside {C_CMD_SDEC32, C_CMD_UDEC32};
    assign is_hex = i_command inside {C_CMD_HEX32L, C_CMD_HEX32U, C_CMD_HEX64L};
    assign bcd_start = accept && is_dec;

    always_comb begin
        if (i_command == C_CMD_SDEC32 && i_value[31]) begin
            mag = 32'd0 - i_value[31:0];
        end else begin
            mag = i_value[31:0];
        end
    end

    always_comb begin
        load = '0;
        if (bcd_done) begin
            load.valid = 1'b1;
            load.dig   = {bcd, {(C_DIG_W - C_BCD_W){1'b0}}};
            load.n     = C_DEC_DIGITS;
            load.neg   = r_neg;
        end else if (accept && is_hex) begin
            load.valid = 1'b1;
            load.upper = (i_command == C_CMD_HEX32U);
            if (i_command == C_CMD_HEX64L) begin
                load.dig = i_value;
                load.n   = C_HEX64_DIGITS;
            end else begin
                load.dig = {i_value[31:0], 32'd0};
                load.n   = C_HEX32_DIGITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_neg  <= 1'b0;
        end else begin
            if (accept && (is_dec || is_hex)) begin
                r_busy <= 1'b1;
                r_neg  <= (i_command == C_CMD_SDEC32) && i_value[31];
            end else if (o_out_valid && i_out_ready && o_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_in_ready = !r_busy;

    itaf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_bin   (mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    itaf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

endmodule

[design/itaf_bcd.sv]
// Serial binary to BCD converter, one shift-add-3 step per cycle.
module itaf_bcd
    import itaf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [C_BIN_W-1:0]   i_bin,
    output logic                 o_done,
    output logic [C_BCD_W-1:0]   o_bcd
);

    logic [C_BIN_W-1:0] r_bin;
    logic [C_BCD_W-1:0] r_bcd;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [C_BCD_W-1:0] n_adj;

    always_comb begin
        for (int k = 0; k < C_BCD_W / 4; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                n_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                n_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_bin;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= {n_adj[C_BCD_W-2:0], r_bin[C_BIN_W-1]};
                r_bin <= {r_bin[C_BIN_W-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(C_BIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

[design/itaf_emit.sv]
// Digit shifter: drops leading zeros, then sends sign and digits as ASCII.
module itaf_emit
    import itaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_load       i_load,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_character,
    output logic        o_last,
    output logic [4:0]  o_char_count
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STRIP = 2'd1;
    localparam logic [1:0] S_SIGN  = 2'd2;
    localparam logic [1:0] S_DIGIT = 2'd3;

    logic [1:0]         r_state;
    logic [C_DIG_W-1:0] r_dig;
    logic [4:0]         r_n;
    logic               r_neg;
    logic               r_upper;
    logic [4:0]         r_cnt;
    logic               r_ovalid;
    logic [6:0]         r_char;
    logic               r_last;
    logic [4:0]         r_ocnt;
    logic               slot_free;
    logic               emit_now;
    logic [3:0]         top_nib;
    logic [6:0]         n_char;

    assign slot_free = !r_ovalid || i_out_ready;
    assign emit_now  = slot_free && (r_state inside {S_SIGN, S_DIGIT});
    assign top_nib   = r_dig[C_DIG_W-1 -: 4];

    always_comb begin
        if (top_nib < 4'd10) begin
            n_char = C_ASCII_ZERO + {3'b0, top_nib};
        end else if (r_upper) begin
            n_char = C_UPPER_OFF + {3'b0, top_nib};
        end else begin
            n_char = C_LOWER_OFF + {3'b0, top_nib};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (emit_now) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_load.valid) begin
                        r_dig   <= i_load.dig;
                        r_n     <= i_load.n;
                        r_neg   <= i_load.neg;
                        r_upper <= i_load.upper;
                        r_cnt   <= '0;
                        r_state <= S_STRIP;
                    end
                end
                S_STRIP: begin
                    if (r_n > 5'd1 && top_nib == 4'd0) begin
                        r_dig <= {r_dig[C_DIG_W-5:0], 4'd0};
                        r_n   <= r_n - 5'd1;
                    end else if (r_neg) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_state <= S_DIGIT;
                    end
                end
                S_SIGN: begin
                    if (slot_free) begin
                        r_char   <= C_ASCII_MINUS;
                        r_last   <= 1'b0;
                        r_ocnt   <= r_cnt + 5'd1;
                        r_cnt    <= r_cnt + 5'd1;
                        r_state  <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (slot_free) begin
                        r_char   <= n_char;
                        r_last   <= (r_n == 5'd1);
                        r_ocnt   <= r_cnt + 5'd1;
                        r_cnt    <= r_cnt + 5'd1;
                        r_dig    <= {r_dig[C_DIG_W-5:0], 4'd0};
                        r_n      <= r_n - 5'd1;
                        if (r_n == 5'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_character  = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_ocnt;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for integer_to_ascii_formatter: directed table, then random traffic.
module tb_top;
    import itaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int NUM_RANDOM   = 220;
    localparam int SLOW_PCT     = 82;
    localparam int FAST_PCT     = 9;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_ITEM = 200;
    localparam int DRAIN_CYCLES = 64;
    localparam int LIMIT_CYCLES = 400_000;

    typedef struct packed {
        logic [6:0] chr;
        logic       is_last;
        logic [4:0] count;
    } t_char_xfer;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] value;
        bit          typed;
        string       text;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_command = '0;
    logic [63:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [6:0]  o_character;
    logic        o_last;
    logic [4:0]  o_char_count;

    t_char_xfer  pending_chars[$];
    t_char_xfer  want;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          sender_idle_pct = FAST_PCT;
    int          recv_idle_pct = SLOW_PCT;
    bit          hold_out_req = 1'b0;

    t_directed_row directed_rows [24] = '{
        '{C_CMD_SDEC32, 64'h0,                     1'b1, "0"},
        '{C_CMD_SDEC32, 64'h0000_0000_7FFF_FFFF,   1'b1, "2147483647"},
        '{C_CMD_SDEC32, 64'h0000_0000_8000_0000,   1'b1, "-2147483648"},
        '{C_CMD_SDEC32, 64'h0000_0000_FFFF_FFFF,   1'b1, "-1"},
        '{C_CMD_SDEC32, 64'hFFFF_FFFF_0000_0005,   1'b1, "5"},
        '{C_CMD_SDEC32, 64'h0000_0000_FFFF_FF9C,   1'b1, "-100"},
        '{C_CMD_SDEC32, 64'h0000_0000_0000_3039,   1'b0, ""},
        '{C_CMD_UDEC32, 64'h0,                     1'b1, "0"},
        '{C_CMD_UDEC32, 64'h0000_0000_FFFF_FFFF,   1'b1, "4294967295"},
        '{C_CMD_UDEC32, 64'hABCD_0000_0000_000A,   1'b1, "10"},
        '{C_CMD_UDEC32, 64'h0000_0000_8000_0000,   1'b0, ""},
        '{C_CMD_HEX32L, 64'h0,                     1'b1, "0"},
        '{C_CMD_HEX32L, 64'h0000_0000_FFFF_FFFF,   1'b1, "ffffffff"},
        '{C_CMD_HEX32L, 64'h1234_0000_DEAD_BEEF,   1'b1, "deadbeef"},
        '{C_CMD_HEX32U, 64'h0000_0000_DEAD_BEEF,   1'b1, "DEADBEEF"},
        '{C_CMD_HEX32U, 64'hFFFF_FFFF_0000_000A,   1'b1, "A"},
        '{C_CMD_HEX32U, 64'h0000_0000_0000_F00D,   1'b0, ""},
        '{C_CMD_HEX64L, 64'h0,                     1'b1, "0"},
        '{C_CMD_HEX64L, 64'hFFFF_FFFF_FFFF_FFFF,   1'b1, "ffffffffffffffff"},
        '{C_CMD_HEX64L, 64'h8000_0000_0000_0000,   1'b1, "8000000000000000"},
        '{C_CMD_HEX64L, 64'h0123_4567_89AB_CDEF,   1'b1, "123456789abcdef"},
        '{CMD_RSVD5,    64'hFFFF_FFFF_FFFF_FFFF,   1'b1, ""},
        '{CMD_RSVD6,    64'h0,                     1'b1, ""},
        '{CMD_RSVD7,    64'h5555_AAAA_5555_AAAA,   1'b1, ""}
    };

    integer_to_ascii_formatter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Text the block should print for one command/value pair; empty when dropped.
    function automatic string format_number(logic [2:0] cmd, logic [63:0] val);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] digit;
        logic [6:0]  letter_base;
        logic [6:0]  chr;
        bit          neg;
        string       s;
        neg = 1'b0;
        letter_base = C_LOWER_OFF;
        radix = 64'd16;
        mag = {32'h0, val[31:0]};
        case (cmd)
            C_CMD_SDEC32: begin
                neg = val[31];
                if (neg) mag = 64'h1_0000_0000 - {32'h0, val[31:0]};
                radix = 64'd10;
            end
            C_CMD_UDEC32: radix = 64'd10;
            C_CMD_HEX32L: ;
            C_CMD_HEX32U: letter_base = C_UPPER_OFF;
            C_CMD_HEX64L: mag = val;
            default: return "";
        endcase
        s = "";
        do begin
            digit = mag % radix;
            mag = mag / radix;
            chr = (digit < 64'd10) ? C_ASCII_ZERO + digit[6:0] : letter_base + digit[6:0];
            s = $sformatf("%c%s", chr, s);
        end while (mag != 64'd0);
        if (neg) s = {"-", s};
        return s;
    endfunction

    function automatic void queue_chars(string s);
        byte b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            pending_chars.push_back('{b[6:0], (i == s.len() - 1), 5'(i + 1)});
        end
    endfunction

    task automatic report_mismatch(string what, int exp_val, int got_val);
        $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                 what, exp_val, got_val, cycle_cnt);
        mismatch_cnt++;
    endtask

    function automatic logic [63:0] random_value();
        logic [31:0] low_word;
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(20));
            2: return {$urandom, $urandom} >> $urandom_range(63);
            3: begin
                case ($urandom_range(4))
                    0: low_word = 32'h8000_0000;
                    1: low_word = 32'h7FFF_FFFF;
                    2: low_word = 32'hFFFF_FFFF;
                    3: low_word = 32'h8000_0001;
                    default: low_word = 32'h0;
                endcase
                return {$urandom, low_word};
            end
            4: return (64'h1 << $urandom_range(63)) - 64'($urandom_range(1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [63:0] val, bit typed, string text);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        queue_chars(typed ? text : format_number(cmd, val));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character transfer", -1, o_character);
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.chr)
                    report_mismatch("character", want.chr, o_character);
                if (o_last !== want.is_last)
                    report_mismatch("last flag", want.is_last, o_last);
                if (o_char_count !== want.count)
                    report_mismatch("char count", want.count, o_char_count);
            end
        end
    end

    // Output side: random back-pressure plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_out_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        logic [2:0]  cmd;
        logic [63:0] val;
        int          n_sent;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].cmd, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].text);

        n_sent = 0;
        while (n_sent < NUM_RANDOM) begin
            if (n_sent < NUM_RANDOM / 3) begin
                sender_idle_pct = FAST_PCT;
                recv_idle_pct   = SLOW_PCT;
            end else if (n_sent < 2 * NUM_RANDOM / 3) begin
                sender_idle_pct = SLOW_PCT;
                recv_idle_pct   = FAST_PCT;
            end else begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            if ($urandom_range(15) == 0)
                cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
            else
                cmd = 3'($urandom_range(C_CMD_HEX64L, C_CMD_SDEC32));
            val = random_value();
            send_item(cmd, val, 1'b0, "");
            if (cmd <= C_CMD_HEX64L) begin
                n_sent++;
                if (n_sent == HOLD_AT_ITEM) hold_out_req = 1'b1;
            end
        end
        i_in_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
